/* rtl/i2cseq_pkg.sv */
// Shared types and constants for the I2C master transaction sequencer.
package i2cseq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_DONE  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_W_START = 4'd1,
    PH_W_ADDR  = 4'd2,
    PH_W_DATA  = 4'd3,
    PH_R_START = 4'd4,
    PH_R_ADDR  = 4'd5,
    PH_R_ACK   = 4'd6,
    PH_R_NACK  = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_OK    = 2'd0,
    OUT_NAK   = 2'd1,
    OUT_UNEXP = 2'd2
  } outcome_e;

  // Engine status codes (bits 7..3 only)
  localparam logic [7:0] ST_MASK       = 8'hF8;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_RSTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_SLA_W_NAK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
  localparam logic [7:0] ST_DATA_W_NAK = 8'h30;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_SLA_R_NAK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
  localparam logic [7:0] ST_DATA_R_NAK = 8'h58;
  localparam logic [7:0] ADDR_W_MASK   = 8'hFE;
  localparam logic [7:0] ADDR_R_BIT    = 8'h01;

  localparam logic [7:0] DEV_ADDR_RST  = 8'hA3;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] command_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       finished;
    outcome_e   outcome;
    logic [7:0] fail_status;
  } result_t;

endpackage

/* rtl/i2c_master_transaction_sequencer.sv */
// A result is registered and offered on the master side in the cycle after its input.
// Throughput: one item per cycle; one state step plus a registered buffer read per item.
// The output register frees in the cycle its result is taken, so the input never stalls
// unless the master side does.
// Reset (rst_ni low, async): phase idle, buffer empty, counts zero, address 0xA3,
// no result pending. Buffer contents are not cleared.
module i2c_master_transaction_sequencer import i2cseq_pkg::*; #(
  parameter int WRITE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: device address
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] load_byte, [12:8] write_count, [28:13] read_count,
  // [36:29] bus_status, [44:37] bus_rx_byte, [47:45] zero
  input  logic [47:0] s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser_i,
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] command_byte, [15:8] read_byte, [17:16] outcome,
  // [25:18] fail_status, [31:26] zero
  output logic [31:0] m_axis_tdata_o,
  // [2:0] command, [3] read_valid
  output logic [3:0]  m_axis_tuser_o,
  // finished
  output logic        m_axis_tlast_o
);

  logic       accept;
  logic [7:0] dev_addr_q;
  result_t    res;
  result_t    out_q;
  logic       out_valid_q, out_valid_d;

  // Accept while the result register is empty or being drained this cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RST;
    end else if (cfg_wr_en_i) begin
      dev_addr_q <= cfg_wr_data_i;
    end
  end

  i2cseq_fsm #(
    .WRITE_DEPTH (WRITE_DEPTH)
  ) u_fsm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .op_i             (op_e'(s_axis_tuser_i)),
    .load_byte_i      (s_axis_tdata_i[7:0]),
    .write_count_i    (s_axis_tdata_i[12:8]),
    .read_count_i     (s_axis_tdata_i[28:13]),
    .bus_status_i     (s_axis_tdata_i[36:29]),
    .bus_rx_byte_i    (s_axis_tdata_i[44:37]),
    .device_address_i (dev_addr_q),
    .result_o         (res)
  );

  // Result register: every accepted item yields exactly one result transfer.
  assign out_valid_d = accept || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_q.fail_status, out_q.outcome, out_q.read_byte,
                            out_q.command_byte};
  assign m_axis_tuser_o  = {out_q.read_valid, out_q.command};
  assign m_axis_tlast_o  = out_q.finished;

endmodule

/* rtl/i2cseq_ram.sv */
// Generic single-port-write, registered-read RAM.
module i2cseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/i2cseq_fsm.sv */
// Transaction state machine, write buffer and per-item result logic.
module i2cseq_fsm import i2cseq_pkg::*; #(
  parameter int WRITE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  op_e         op_i,
  input  logic [7:0]  load_byte_i,
  input  logic [4:0]  write_count_i,
  input  logic [15:0] read_count_i,
  input  logic [7:0]  bus_status_i,
  input  logic [7:0]  bus_rx_byte_i,
  input  logic [7:0]  device_address_i,
  output result_t     result_o
);

  localparam int AW = $clog2(WRITE_DEPTH);
  localparam int CW = $clog2(WRITE_DEPTH + 1);
  localparam int MW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] DEPTH_C = CW'(WRITE_DEPTH);

  phase_e        phase_q, phase_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] windex_q, windex_d;
  logic [CW-1:0] wleft_q, wleft_d;
  logic [15:0]   rleft_q, rleft_d;
  logic          wrote_q, wrote_d;

  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [7:0]    st;
  logic [MW-1:0] wc_ext, fill_ext;
  logic          fail;
  logic [7:0]    ok_code, nak_code;
  result_t       res;

  // Read address follows the next index so the data lines up with the next completion.
  i2cseq_ram #(
    .WIDTH (8),
    .DEPTH (WRITE_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (load_byte_i),
    .raddr_i (windex_d[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign st       = bus_status_i & ST_MASK;
  assign wc_ext   = MW'(write_count_i);
  assign fill_ext = MW'(fill_q);
  assign ok_code  = (phase_q == PH_W_ADDR) ? ST_SLA_W_ACK : ST_DATA_W_ACK;
  assign nak_code = (phase_q == PH_W_ADDR) ? ST_SLA_W_NAK : ST_DATA_W_NAK;

  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    windex_d = windex_q;
    wleft_d  = wleft_q;
    rleft_d  = rleft_q;
    wrote_d  = wrote_q;
    ram_we   = 1'b0;
    fail     = 1'b0;
    res      = '0;

    if (accept_i) begin
      case (op_i)
        OP_LOAD: begin
          if (phase_q == PH_IDLE && fill_q < DEPTH_C) begin
            ram_we = 1'b1;
            fill_d = fill_q + 1'b1;
          end
        end
        OP_BEGIN: begin
          if (phase_q == PH_IDLE) begin
            wleft_d  = (wc_ext < fill_ext) ? wc_ext[CW-1:0] : fill_q;
            rleft_d  = read_count_i;
            windex_d = '0;
            fill_d   = '0;
            if (wleft_d != '0) begin
              wrote_d     = 1'b1;
              phase_d     = PH_W_START;
              res.command = CMD_START;
            end else if (read_count_i != '0) begin
              wrote_d     = 1'b0;
              phase_d     = PH_R_START;
              res.command = CMD_START;
            end else begin
              wrote_d      = 1'b0;
              res.finished = 1'b1;
            end
          end
        end
        OP_DONE: begin
          case (phase_q)
            PH_IDLE: ;
            PH_W_START: begin
              if (st == ST_START) begin
                phase_d          = PH_W_ADDR;
                res.command      = CMD_SEND;
                res.command_byte = device_address_i & ADDR_W_MASK;
              end else begin
                fail = 1'b1;
              end
            end
            PH_W_ADDR, PH_W_DATA: begin
              if (st == ok_code) begin
                if (wleft_q != '0 && windex_q < DEPTH_C) begin
                  windex_d         = windex_q + 1'b1;
                  wleft_d          = wleft_q - 1'b1;
                  phase_d          = PH_W_DATA;
                  res.command      = CMD_SEND;
                  res.command_byte = ram_rdata;
                end else if (rleft_q != '0) begin
                  phase_d     = PH_R_START;
                  res.command = CMD_START;
                end else begin
                  phase_d      = PH_IDLE;
                  res.command  = CMD_STOP;
                  res.finished = 1'b1;
                end
              end else if (st == nak_code) begin
                phase_d         = PH_IDLE;
                res.command     = CMD_STOP;
                res.finished    = 1'b1;
                res.outcome     = OUT_NAK;
                res.fail_status = st;
              end else begin
                fail = 1'b1;
              end
            end
            PH_R_START: begin
              if (st == (wrote_q ? ST_RSTART : ST_START)) begin
                phase_d          = PH_R_ADDR;
                res.command      = CMD_SEND;
                res.command_byte = device_address_i | ADDR_R_BIT;
              end else begin
                fail = 1'b1;
              end
            end
            PH_R_ADDR: begin
              if (st == ST_SLA_R_ACK) begin
                phase_d     = (rleft_q > 16'd1) ? PH_R_ACK : PH_R_NACK;
                res.command = (rleft_q > 16'd1) ? CMD_RX_ACK : CMD_RX_NACK;
              end else if (st == ST_SLA_R_NAK) begin
                phase_d         = PH_IDLE;
                res.command     = CMD_STOP;
                res.finished    = 1'b1;
                res.outcome     = OUT_NAK;
                res.fail_status = st;
              end else begin
                fail = 1'b1;
              end
            end
            PH_R_ACK: begin
              if (st == ST_DATA_R_ACK) begin
                rleft_d        = (rleft_q != '0) ? rleft_q - 1'b1 : rleft_q;
                phase_d        = (rleft_d > 16'd1) ? PH_R_ACK : PH_R_NACK;
                res.command    = (rleft_d > 16'd1) ? CMD_RX_ACK : CMD_RX_NACK;
                res.read_valid = 1'b1;
                res.read_byte  = bus_rx_byte_i;
              end else begin
                fail = 1'b1;
              end
            end
            PH_R_NACK: begin
              if (st == ST_DATA_R_NAK) begin
                rleft_d        = '0;
                phase_d        = PH_IDLE;
                res.command    = CMD_STOP;
                res.read_valid = 1'b1;
                res.read_byte  = bus_rx_byte_i;
                res.finished   = 1'b1;
              end else begin
                fail = 1'b1;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
          // unexpected status: abort, no STOP
          if (fail) begin
            phase_d         = PH_IDLE;
            res             = '0;
            res.finished    = 1'b1;
            res.outcome     = OUT_UNEXP;
            res.fail_status = st;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      fill_q   <= '0;
      windex_q <= '0;
      wleft_q  <= '0;
      rleft_q  <= '0;
      wrote_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      windex_q <= windex_d;
      wleft_q  <= wleft_d;
      rleft_q  <= rleft_d;
      wrote_q  <= wrote_d;
    end
  end

  assign result_o = res;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_C)
    else $error("buffer fill beyond depth");

  a_busy_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> fill_q == '0)
    else $error("buffer filled during a transaction");

  a_ack_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_R_ACK |-> rleft_q > 16'd1)
    else $error("ACK read phase with one or no read left");

  // a masked status of zero is a legal abort code, so only finished is implied
  a_outcome_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.outcome != OUT_OK |-> res.finished)
    else $error("failure outcome on an unfinished item");

endmodule

/* test/i2c_master_transaction_sequencer_tb.sv */
// Self-checking testbench for the I2C master write-then-read transaction sequencer.
`timescale 1ns / 100ps

module i2c_master_transaction_sequencer_tb;
  import i2cseq_pkg::*;

  localparam int WRITE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  // op code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [7:0]  cfg_wr_data_i = 8'h00;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [7:0] load_byte, [12:8] write_count, [28:13] read_count,
  // [36:29] bus_status, [44:37] bus_rx_byte, [47:45] zero
  logic [47:0] s_axis_tdata_i = '0;
  // [1:0] op
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] command_byte, [15:8] read_byte, [17:16] outcome,
  // [25:18] fail_status, [31:26] zero
  logic [31:0] m_axis_tdata_o;
  // [2:0] command, [3] read_valid
  logic [3:0]  m_axis_tuser_o;
  // finished
  logic        m_axis_tlast_o;

  i2c_master_transaction_sequencer #(
    .WRITE_DEPTH(WRITE_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer state as the testbench sees it, advanced on every accepted input
  // ---------------------------------------------------------------------------
  phase_e      ph = PH_IDLE;
  logic [7:0]  dev_addr = DEV_ADDR_RST;
  logic [7:0]  wbuf [WRITE_DEPTH];
  logic [4:0]  fill = '0;
  logic [4:0]  widx = '0;
  logic [4:0]  wleft = '0;
  logic [15:0] rleft = '0;
  bit          wrote = 1'b0;

  result_t     due_actions[$];   // bus actions predicted, not yet seen
  int          errors = 0;
  int          useful_items = 0;  // inputs that the sequencer acts on
  int          cycle_count = 0;

  // idling controls shared by the sender, the receiver and the tests
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;
  int          hold_left = 0;     // long receiver hold-off requested by a test
  int          stall_left = 0;

  // read phase entry: every byte but the last gets ACK
  function automatic cmd_e next_read_cmd();
    if (rleft > 1) begin
      ph = PH_R_ACK;
      return CMD_RX_ACK;
    end
    ph = PH_R_NACK;
    return CMD_RX_NACK;
  endfunction

  // engine completion: advance on the expected status, NAK ends with STOP,
  // anything else aborts without STOP
  function automatic result_t bus_completion(input logic [7:0] st, input logic [7:0] rx);
    result_t    r;
    logic [7:0] ok_code;
    logic [7:0] nak_code;
    bit         matched;
    r = '0;
    matched = 1'b1;
    case (ph)
      PH_W_START: begin
        if (st == ST_START) begin
          ph = PH_W_ADDR;
          r.command = CMD_SEND;
          r.command_byte = dev_addr & ADDR_W_MASK;
        end else matched = 1'b0;
      end
      PH_W_ADDR, PH_W_DATA: begin
        ok_code  = (ph == PH_W_ADDR) ? ST_SLA_W_ACK : ST_DATA_W_ACK;
        nak_code = (ph == PH_W_ADDR) ? ST_SLA_W_NAK : ST_DATA_W_NAK;
        if (st == ok_code) begin
          if (wleft != 0 && widx < WRITE_DEPTH) begin
            r.command = CMD_SEND;
            r.command_byte = wbuf[widx];
            widx++;
            wleft--;
            ph = PH_W_DATA;
          end else if (rleft != 0) begin
            ph = PH_R_START;
            r.command = CMD_START;
          end else begin
            ph = PH_IDLE;
            r.command = CMD_STOP;
            r.finished = 1'b1;
          end
        end else if (st == nak_code) begin
          ph = PH_IDLE;
          r.command = CMD_STOP;
          r.finished = 1'b1;
          r.outcome = OUT_NAK;
          r.fail_status = st;
        end else matched = 1'b0;
      end
      PH_R_START: begin
        if (st == (wrote ? ST_RSTART : ST_START)) begin
          ph = PH_R_ADDR;
          r.command = CMD_SEND;
          r.command_byte = dev_addr | ADDR_R_BIT;
        end else matched = 1'b0;
      end
      PH_R_ADDR: begin
        if (st == ST_SLA_R_ACK) begin
          r.command = next_read_cmd();
        end else if (st == ST_SLA_R_NAK) begin
          ph = PH_IDLE;
          r.command = CMD_STOP;
          r.finished = 1'b1;
          r.outcome = OUT_NAK;
          r.fail_status = st;
        end else matched = 1'b0;
      end
      PH_R_ACK: begin
        if (st == ST_DATA_R_ACK) begin
          if (rleft != 0) rleft--;
          r.command = next_read_cmd();
          r.read_valid = 1'b1;
          r.read_byte = rx;
        end else matched = 1'b0;
      end
      PH_R_NACK: begin
        if (st == ST_DATA_R_NAK) begin
          rleft = '0;
          ph = PH_IDLE;
          r.command = CMD_STOP;
          r.read_valid = 1'b1;
          r.read_byte = rx;
          r.finished = 1'b1;
        end else matched = 1'b0;
      end
      default: ph = PH_IDLE;
    endcase
    if (!matched) begin
      ph = PH_IDLE;
      r.finished = 1'b1;
      r.outcome = OUT_UNEXP;
      r.fail_status = st;
    end
    return r;
  endfunction

  // bus action caused by one input transfer
  function automatic result_t next_bus_action(input logic [1:0] op, input logic [7:0] ld,
                                              input logic [4:0] wc, input logic [15:0] rc,
                                              input logic [7:0] st_raw, input logic [7:0] rx);
    result_t r;
    r = '0;
    case (op)
      OP_LOAD: begin
        // loads only land while idle and the buffer has room
        if (ph == PH_IDLE && fill < WRITE_DEPTH) begin
          wbuf[fill] = ld;
          fill++;
        end
      end
      OP_BEGIN: begin
        if (ph == PH_IDLE) begin
          wleft = (wc < fill) ? wc : fill;  // never write past what was loaded
          rleft = rc;
          widx = '0;
          fill = '0;
          if (wleft != 0) begin
            wrote = 1'b1;
            ph = PH_W_START;
            r.command = CMD_START;
          end else if (rleft != 0) begin
            wrote = 1'b0;
            ph = PH_R_START;
            r.command = CMD_START;
          end else begin
            wrote = 1'b0;
            r.finished = 1'b1;
          end
        end
      end
      OP_DONE: begin
        if (ph != PH_IDLE) r = bus_completion(st_raw & ST_MASK, rx);
      end
      default: ;
    endcase
    return r;
  endfunction

  // status the engine reports when the current command went as planned
  function automatic logic [7:0] good_status();
    case (ph)
      PH_W_START: return ST_START;
      PH_W_ADDR:  return ST_SLA_W_ACK;
      PH_W_DATA:  return ST_DATA_W_ACK;
      PH_R_START: return wrote ? ST_RSTART : ST_START;
      PH_R_ADDR:  return ST_SLA_R_ACK;
      PH_R_ACK:   return ST_DATA_R_ACK;
      PH_R_NACK:  return ST_DATA_R_NAK;
      default:    return ST_START;
    endcase
  endfunction

  // NAK where the phase has one (if asked), otherwise any off-plan status
  function automatic logic [7:0] fault_status(input bit want_nak);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 7));
    if (want_nak && ph == PH_W_ADDR) return ST_SLA_W_NAK | junk;
    if (want_nak && ph == PH_W_DATA) return ST_DATA_W_NAK | junk;
    if (want_nak && ph == PH_R_ADDR) return ST_SLA_R_NAK | junk;
    do junk = 8'($urandom()); while ((junk & ST_MASK) == good_status());
    return junk;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [7:0] ld, input logic [4:0] wc,
                           input logic [15:0] rc, input logic [7:0] st, input logic [7:0] rx);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, rx, st, rc, wc, ld};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if ((op == OP_LOAD && ph == PH_IDLE && fill < WRITE_DEPTH) ||
        (op == OP_BEGIN && ph == PH_IDLE) || (op == OP_DONE && ph != PH_IDLE))
      useful_items++;
    due_actions.push_back(next_bus_action(op, ld, wc, rc, st, rx));
  endtask

  // unused fields carry random values so their input bits toggle
  task automatic send_load(input logic [7:0] b);
    send_item(OP_LOAD, b, 5'($urandom()), 16'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  task automatic send_begin(input logic [4:0] wc, input logic [15:0] rc);
    send_item(OP_BEGIN, 8'($urandom()), wc, rc, 8'($urandom()), 8'($urandom()));
  endtask

  task automatic send_done(input logic [7:0] st, input logic [7:0] rx);
    send_item(OP_DONE, 8'($urandom()), 5'($urandom()), 16'($urandom()), st, rx);
  endtask

  // an item the sequencer should not act on in its present phase, or an empty begin while idle
  task automatic stray_item();
    case ($urandom_range(0, 2))
      0: send_item(OP_UNUSED, 8'($urandom()), 5'($urandom()), 16'($urandom()),
                   8'($urandom()), 8'($urandom()));
      1: if (ph == PH_IDLE) send_done(8'($urandom()), 8'($urandom()));
         else send_load(8'($urandom()));
      default: if (ph == PH_IDLE) send_begin(5'($urandom_range(0, 16)), 16'd0);
               else send_begin(5'($urandom_range(0, 16)), 16'($urandom()));
    endcase
  endtask

  // stop offering and wait until every predicted action has come out
  task automatic drain();
    @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
    while (due_actions.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] a);
    drain();
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= a;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    dev_addr = a;
  endtask

  // Load, begin, then answer each bus command as the engine would until the
  // sequencer is idle again. fault_step < 0 means a clean run; a long read
  // is cut short after 40 completions with an off-plan status.
  task automatic run_transaction(input int n_load, input int wc, input int rc,
                                 input int fault_step, input bit fault_nak,
                                 input int noise_pct);
    int         step;
    logic [7:0] st;
    repeat (n_load) send_load(8'($urandom()));
    send_begin(5'(wc), 16'(rc));
    step = 0;
    while (ph != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) stray_item();
      if ($urandom_range(0, 39) == 0) drain();
      if (step == fault_step || step >= 40)
        st = fault_status(fault_nak && step == fault_step);
      else
        st = good_status() | 8'($urandom_range(0, 7));
      send_done(st, 8'($urandom()));
      step++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!receiver_steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_bus_action
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.command      = cmd_e'(m_axis_tuser_o[2:0]);
      got.read_valid   = m_axis_tuser_o[3];
      got.command_byte = m_axis_tdata_o[7:0];
      got.read_byte    = m_axis_tdata_o[15:8];
      got.outcome      = outcome_e'(m_axis_tdata_o[17:16]);
      got.fail_status  = m_axis_tdata_o[25:18];
      got.finished     = m_axis_tlast_o;
      if (due_actions.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, tuser %h tdata %h tlast %b",
                 $time, m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        want = due_actions.pop_front();
        check_field("command", 8'(want.command), 8'(got.command));
        check_field("command_byte", want.command_byte, got.command_byte);
        check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
        check_field("read_byte", want.read_byte, got.read_byte);
        check_field("finished", 8'(want.finished), 8'(got.finished));
        check_field("outcome", 8'(want.outcome), 8'(got.outcome));
        check_field("fail_status", want.fail_status, got.fail_status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // full write-then-read with repeated START at the reset address, extreme bytes
  task automatic test_write_then_read();
    send_load(8'h00);
    send_load(8'hFF);
    run_transaction(0, 2, 2, -1, 1'b0, 0);
  endtask

  // empty transaction, unused op code, completion while idle
  task automatic test_idle_items();
    send_begin(5'd0, 16'd0);
    send_item(OP_UNUSED, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF, 8'hFF);
    send_done(ST_START, 8'h00);
  endtask

  // write count above fill is clamped; nothing loaded means a read-only run
  // with plain START, here with the widest read count and an abort midway
  task automatic test_count_clamping();
    run_transaction(1, 16, 1, -1, 1'b0, 0);
    run_transaction(0, 5, 16'hFFFF, 6, 1'b0, 0);
  endtask

  // loads and begins offered mid-transaction are ignored
  task automatic test_busy_items();
    run_transaction(2, 2, 2, -1, 1'b0, 100);
  endtask

  // NAK on each address/data phase ends with STOP; an off-plan status aborts
  task automatic test_failures();
    run_transaction(1, 1, 0, 1, 1'b1, 0);
    run_transaction(2, 2, 0, 2, 1'b1, 0);
    run_transaction(0, 0, 1, 1, 1'b1, 0);
    run_transaction(0, 0, 2, 0, 1'b0, 0);
  endtask

  // loads past the buffer depth are dropped
  task automatic test_full_buffer();
    repeat (WRITE_DEPTH + 2) send_load(8'($urandom()));
    run_transaction(0, 16, 0, 4, 1'b1, 0);
  endtask

  task automatic test_address_extremes();
    write_address(8'h00);
    run_transaction(1, 1, 2, -1, 1'b0, 0);
    write_address(8'hFF);
    run_transaction(2, 2, 1, -1, 1'b0, 0);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_hold();
    drain();
    sender_steady = 1'b1;
    hold_left = 60;
    run_transaction(4, 4, 3, -1, 1'b0, 0);
    sender_steady = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic(input int target);
    int first;
    int n_load;
    int wc;
    int rc;
    int fault_step;
    first = useful_items;
    while (useful_items - first < target) begin
      if ($urandom_range(0, 24) == 0) write_address(8'($urandom()));
      if ($urandom_range(0, 9) == 0) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) == 0) stray_item();
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 4);
      wc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : n_load;
      rc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
      fault_step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : -1;
      run_transaction(n_load, wc, rc, fault_step, 1'($urandom()), 5);
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_write_then_read();
    test_idle_items();
    test_count_clamping();
    test_busy_items();
    test_failures();
    test_full_buffer();
    test_address_extremes();
    test_output_hold();
    test_random_traffic(310);

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
